@@ sv/kli_pkg.sv @@
package kli_pkg;

	// Fixed field widths
	localparam int TIME_W  = 32;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;
	localparam int KIND_W  = 2;

	// Request operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result source codes
	localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INTERP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LAST   = 2'd2;

	// Value component select
	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]  t;
		logic [VALUE_W-1:0] x;
		logic [VALUE_W-1:0] y;
		logic [VALUE_W-1:0] z;
	} key_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SCAN,
		ST_DIV,
		ST_SUB,
		ST_MUL,
		ST_ADD,
		ST_LOAD
	} ctl_state_t;

	typedef struct packed {
		logic              mem_write;
		logic              cap_query;
		logic              take_key;
		logic [KIND_W-1:0] key_kind;
		logic              shift_prev;
		logic              div_start;
		logic              div_step;
		logic              div_first;
		logic              sub;
		logic              mul;
		logic              add;
		logic [1:0]        comp;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic q_le_rd;
		logic bracket;
	} dp_stat_t;

endpackage

@@ sv/kli_dpath.sv @@
module kli_dpath import kli_pkg::*; #(
	parameter int KEY_SLOTS     = 64,
	parameter int FRACTION_BITS = 16,
	localparam int AW = $clog2(KEY_SLOTS)
) (
	input  logic                       clk,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  logic [AW-1:0]              rd_addr,
	input  logic [INDEX_W-1:0]         key_index,
	input  logic [TIME_W-1:0]          key_time,
	input  logic signed [VALUE_W-1:0]  key_x,
	input  logic signed [VALUE_W-1:0]  key_y,
	input  logic signed [VALUE_W-1:0]  key_z,
	input  logic [TIME_W-1:0]          query_time,
	output logic signed [VALUE_W-1:0]  value_x,
	output logic signed [VALUE_W-1:0]  value_y,
	output logic signed [VALUE_W-1:0]  value_z,
	output logic [KIND_W-1:0]          source_kind
);

	localparam int PW = VALUE_W + 1 + FRACTION_BITS + 2;

	key_entry_t                 mem [KEY_SLOTS];
	key_entry_t                 rd_q;
	key_entry_t                 prev_q;
	logic [VALUE_W-1:0]         cur_x_q, cur_y_q, cur_z_q;
	logic [TIME_W-1:0]          q_q;
	logic [TIME_W-1:0]          rem_q, den_q;
	logic [FRACTION_BITS:0]     quot_q;
	logic [FRACTION_BITS:0]     frac;
	logic [VALUE_W:0]           delta_q;
	logic signed [PW-1:0]       prod_q;
	logic [VALUE_W-1:0]         res_x_q, res_y_q, res_z_q;
	logic [KIND_W-1:0]          res_kind_q;
	logic [VALUE_W-1:0]         v0_sel, v1_sel;
	logic [TIME_W:0]            rem_sh;
	logic                       rem_ge;
	logic                       slot_ok;

	// Table write and registered read
	assign slot_ok = 32'(key_index) < 32'(KEY_SLOTS);

	always_ff @(posedge clk) begin
		if (cmd.mem_write && slot_ok) begin
			mem[AW'(key_index)] <= '{t: key_time, x: key_x, y: key_y, z: key_z};
		end
		rd_q <= mem[rd_addr];
	end

	// Compare query time against the current and previous keys
	assign stat.q_le_rd = q_q <= rd_q.t;
	assign stat.bracket = (prev_q.t <= q_q) && (q_q <= rd_q.t);

	// Select the component being blended
	always_comb begin
		case (cmd.comp)
			COMP_X: begin
				v0_sel = prev_q.x;
				v1_sel = cur_x_q;
			end
			COMP_Y: begin
				v0_sel = prev_q.y;
				v1_sel = cur_y_q;
			end
			default: begin
				v0_sel = prev_q.z;
				v1_sel = cur_z_q;
			end
		endcase
	end

	// One restoring division step; the first step yields the integer bit
	assign rem_sh = cmd.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign rem_ge = rem_sh >= {1'b0, den_q};

	// Equal key times give a zero fraction
	assign frac = (den_q == '0) ? '0 : quot_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_query) begin
			q_q <= query_time;
		end
		if (cmd.shift_prev) begin
			prev_q <= rd_q;
		end
		if (cmd.div_start) begin
			cur_x_q    <= rd_q.x;
			cur_y_q    <= rd_q.y;
			cur_z_q    <= rd_q.z;
			rem_q      <= q_q - prev_q.t;
			den_q      <= rd_q.t - prev_q.t;
			quot_q     <= '0;
			res_kind_q <= KIND_INTERP;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? TIME_W'(rem_sh - {1'b0, den_q}) : rem_sh[TIME_W-1:0];
			quot_q <= {quot_q[FRACTION_BITS-1:0], rem_ge};
		end
		if (cmd.sub) begin
			delta_q <= {v1_sel[VALUE_W-1], v1_sel} - {v0_sel[VALUE_W-1], v0_sel};
		end
		if (cmd.mul) begin
			prod_q <= $signed(delta_q) * $signed({1'b0, frac});
		end
		// Add the floored, scaled delta back onto the start value
		if (cmd.add) begin
			case (cmd.comp)
				COMP_X:  res_x_q <= v0_sel + prod_q[FRACTION_BITS +: VALUE_W];
				COMP_Y:  res_y_q <= v0_sel + prod_q[FRACTION_BITS +: VALUE_W];
				default: res_z_q <= v0_sel + prod_q[FRACTION_BITS +: VALUE_W];
			endcase
		end
		if (cmd.take_key) begin
			res_x_q    <= rd_q.x;
			res_y_q    <= rd_q.y;
			res_z_q    <= rd_q.z;
			res_kind_q <= cmd.key_kind;
		end
		// Hand the result to the output register
		if (cmd.out_load) begin
			value_x     <= res_x_q;
			value_y     <= res_y_q;
			value_z     <= res_z_q;
			source_kind <= res_kind_q;
		end
	end

endmodule

@@ sv/kli_ctrl.sv @@
module kli_ctrl import kli_pkg::*; #(
	parameter int KEY_SLOTS     = 64,
	parameter int FRACTION_BITS = 16,
	localparam int AW  = $clog2(KEY_SLOTS),
	localparam int DCW = $clog2(FRACTION_BITS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               cfg_write,
	input  logic [COUNT_W-1:0] cfg_data,
	output dp_cmd_t            cmd,
	input  dp_stat_t           stat,
	output logic [AW-1:0]      rd_addr
);

	ctl_state_t       state_q, state_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [AW-1:0]    last_q, last_d;
	logic [DCW-1:0]   cnt_q, cnt_d;
	logic [1:0]       comp_q, comp_d;
	logic             out_valid_q;
	logic             in_accept;
	logic             out_free;
	logic [31:0]      cfg_wide;

	assign in_stall  = state_q != ST_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign rd_addr   = (state_q == ST_IDLE) ? '0 : AW'(idx_q + 1'b1);

	// Clamp the key count to 1 .. KEY_SLOTS and keep the last index in use
	assign cfg_wide = 32'(cfg_data);

	always_comb begin
		if (cfg_wide == 32'd0) begin
			last_d = '0;
		end else if (cfg_wide > 32'(KEY_SLOTS)) begin
			last_d = AW'(KEY_SLOTS - 1);
		end else begin
			last_d = AW'(cfg_wide - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			comp_q      <= COMP_X;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			if (cfg_write) begin
				last_q <= last_d;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sequence one request: store a write; for a query scan pairs, divide, blend, deliver
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		comp_d  = comp_q;
		cmd     = '0;
		cmd.comp = comp_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (operation == OP_WRITE) begin
						cmd.mem_write = 1'b1;
					end else begin
						cmd.cap_query = 1'b1;
						idx_d         = '0;
						state_d       = ST_FIRST;
					end
				end
			end
			ST_FIRST: begin
				if (last_q == '0 || stat.q_le_rd) begin
					cmd.take_key = 1'b1;
					cmd.key_kind = KIND_FIRST;
					state_d      = ST_LOAD;
				end else begin
					cmd.shift_prev = 1'b1;
					idx_d          = idx_q + 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.bracket) begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					state_d       = ST_DIV;
				end else if (idx_q == last_q) begin
					cmd.take_key = 1'b1;
					cmd.key_kind = KIND_LAST;
					state_d      = ST_LOAD;
				end else begin
					cmd.shift_prev = 1'b1;
					idx_d          = idx_q + 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = cnt_q == '0;
				if (cnt_q == DCW'(FRACTION_BITS)) begin
					comp_d  = COMP_X;
					state_d = ST_SUB;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				if (comp_q == COMP_Z) begin
					state_d = ST_LOAD;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = ST_SUB;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
		endcase
	end

endmodule

@@ sv/keyframe_linear_interpolator_top.sv @@
// Keyframe linear interpolator. A write request (operation 0) stores one keyframe
// (time, x, y, z); a key_index at or beyond KEY_SLOTS is dropped. A query request
// (operation 1) returns the first key when one key is in use or the query is at or
// before key 0, the blend of the first bracketing pair otherwise, and the last key in
// use when no pair brackets. The block takes one request at a time. A query walks the
// table one entry a cycle, because the table has a single registered read port. An
// interpolated result then passes the bit-serial fraction divider and the three blends
// on one shared multiplier. Results wait in an output register, so the next request
// is taken while a result is still stalled. The user must write keys_in_use only
// while idle; the block itself does not enforce it. A count of 0 acts as 1 and one
// above KEY_SLOTS acts as KEY_SLOTS.
module keyframe_linear_interpolator_top import kli_pkg::*; #(
	parameter int KEY_SLOTS     = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      operation,
	input  logic [INDEX_W-1:0]        key_index,
	input  logic [TIME_W-1:0]         key_time,
	input  logic signed [VALUE_W-1:0] key_x,
	input  logic signed [VALUE_W-1:0] key_y,
	input  logic signed [VALUE_W-1:0] key_z,
	input  logic [TIME_W-1:0]         query_time,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] value_x,
	output logic signed [VALUE_W-1:0] value_y,
	output logic signed [VALUE_W-1:0] value_z,
	output logic [KIND_W-1:0]         source_kind,
	input  logic                      cfg_write,
	input  logic [COUNT_W-1:0]        cfg_data
);

	localparam int AW = $clog2(KEY_SLOTS);

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [AW-1:0] rd_addr;

	kli_ctrl #(
		.KEY_SLOTS     (KEY_SLOTS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.rd_addr   (rd_addr)
	);

	kli_dpath #(
		.KEY_SLOTS     (KEY_SLOTS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.rd_addr     (rd_addr),
		.key_index   (key_index),
		.key_time    (key_time),
		.key_x       (key_x),
		.key_y       (key_y),
		.key_z       (key_z),
		.query_time  (query_time),
		.value_x     (value_x),
		.value_y     (value_y),
		.value_z     (value_z),
		.source_kind (source_kind)
	);

endmodule
